// ----- rtl/assert_macros.svh -----
// Concurrent assertion macros shared by the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, ignored while reset is active.
`define MCFW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also covers the reset cycles.
`define MCFW_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MCFW_ASSERT(lbl, clk, rst_n, prop, msg)

`define MCFW_ASSERT_RST(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/mcfw_pkg.sv -----
// Types, constants and helpers for the cubic filter weight unit.
package mcfw_pkg;

    localparam int FRAC_BITS_DEF = 12;

    localparam int OFFSET_W  = 16;
    localparam int WEIGHT_W  = 16;
    localparam int PARAM_W   = 16;
    localparam int CFG_IDX_W = 4;
    localparam int T_W       = 16;   // |offset|, up to 32768
    localparam int COEF_W    = 24;   // Q14 coefficients
    localparam int ACC_W     = 44;   // Q28 Horner accumulator
    localparam int ACC_LO_W  = 22;   // low part for the split multiply
    localparam int Q14_SHIFT = 14;

    typedef logic signed [OFFSET_W-1:0]  t_offset;
    typedef logic signed [WEIGHT_W-1:0]  t_weight;
    typedef logic        [PARAM_W-1:0]   t_param;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic        [T_W-1:0]       t_mag;
    typedef logic signed [COEF_W-1:0]    t_coef;
    typedef logic signed [ACC_W-1:0]     t_acc;

    localparam t_cfg_idx REG_B_PARAM = t_cfg_idx'(0);
    localparam t_cfg_idx REG_C_PARAM = t_cfg_idx'(1);
    localparam t_param   PARAM_RESET = 16'd5461;

    // Stage enables of one two-stage Horner step.
    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_hstep_en;

    // Q14 coefficient to Q28 accumulator.
    function automatic t_acc widen(input t_coef c);
        widen = {{(ACC_W-COEF_W-Q14_SHIFT){c[COEF_W-1]}}, c, {Q14_SHIFT{1'b0}}};
    endfunction

endpackage

// ----- rtl/mcfw_if.sv -----
// Valid/ready channel interfaces: offset in, weight out, register writes.
interface mcfw_in_if;
    import mcfw_pkg::*;
    logic    valid;
    logic    ready;
    t_offset offset;
    modport source (output valid, output offset, input ready);
    modport sink   (input valid, input offset, output ready);
endinterface

interface mcfw_out_if;
    import mcfw_pkg::*;
    logic    valid;
    logic    ready;
    t_weight weight;
    modport source (output valid, output weight, input ready);
    modport sink   (input valid, input weight, output ready);
endinterface

interface mcfw_cfg_if;
    import mcfw_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_param   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/mitchell_cubic_filter_weight_unit.sv -----
// Mitchell-Netravali cubic filter weight unit: top level with the item pipeline.
//
// Takes a signed Q4.12 sample offset per word and returns the Mitchell-Netravali
// kernel weight as signed Q2.14, saturated, and zero for |offset| >= 2.
// Shape parameters B (index 0) and C (index 1) are unsigned Q2.14 registers,
// both reset to 5461 (about 1/3); writes to other indexes are dropped, and the
// config port is always ready. Write them only while no word is in flight.
// Throughput: one offset per cycle while the output is ready. A word accepted at
// the input sits in stage 0 right after the accepting edge and leaves from stage 9.
// The pipeline is ten register stages:
//   0     |x|, radius tests, coefficient selection from B and C
//   1..6  three Horner steps, each a 22x17 + 22x16 split multiply stage and a
//         recombine/round/add stage
//   7     round into /2^15 and bias for the unsigned divide-by-3
//   8     reciprocal multiply for /3
//   9     unbias, radius mask, saturate (output register)
// Each stage holds its word until the next one frees up, so bubbles are
// squeezed out and a stalled output still lets input flow into empty stages.
// The rounding is floor((v + d/2) / d) throughout.
`include "assert_macros.svh"

module mitchell_cubic_filter_weight_unit #(
    parameter int FRAC_BITS = mcfw_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mcfw_in_if.sink        i_in,
    mcfw_out_if.source     o_out,
    mcfw_cfg_if.sink       i_cfg
);
    import mcfw_pkg::*;

    localparam int NS = 10;                 // pipeline stages
    localparam int U_W = 28;                // biased quotient operand
    localparam int Q_W = U_W - 1;           // signed pre-divide value
    localparam int RCP_W = 29;
    localparam int RCP_SHIFT = 30;
    localparam int P_W = U_W + RCP_W;

    localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;
    localparam logic [31:0] TWO_Q = 32'd2 << FRAC_BITS;
    localparam t_coef Q14_ONE = 24'sd16384;
    localparam t_acc  DIV_BIAS = t_acc'(3) <<< Q14_SHIFT;      // half of 6*2^14
    localparam logic [U_W-1:0] U_BIAS = 28'd201326592;         // 3*2^26
    localparam logic [RCP_W-1:0] RECIP3 = 29'd357913942;       // ceil(2^30/3)
    localparam logic signed [U_W-1:0] Q_BIAS = 28'sd67108864;  // U_BIAS/3
    localparam logic signed [U_W-1:0] W_MAX = 28'sd32767;
    localparam logic signed [U_W-1:0] W_MIN = -28'sd32768;

    typedef struct packed {
        t_mag  t;
        logic  inr;     // |x| < 2
        t_coef c1;
        t_coef c0;
    } t_side;

    // config registers
    t_param r_b, r_c;

    // pipeline control
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    // stage 0
    t_side r_side [0:NS-2];
    t_side n_side;
    t_coef r_c3, r_c2, n_c3, n_c2;

    // Horner chain
    t_acc h1_acc, h2_acc, h3_acc;

    // divide and output stages
    logic [U_W-1:0]          r_u, n_u;
    logic [P_W-1:0]          r_prod;
    t_weight                 r_weight, n_weight;
    logic signed [U_W-1:0]   w_full;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= PARAM_RESET;
            r_c <= PARAM_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_B_PARAM: r_b <= i_cfg.data;
                REG_C_PARAM: r_c <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // A stage loads when it is empty or its word moves on this cycle.
    always_comb begin
        en[NS-1] = !r_v[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_in.valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign i_in.ready = en[0];

    // ---------------- stage 0: magnitude and coefficients ----------------
    always_comb begin
        t_coef bq;
        t_coef cq;
        logic  near;
        bq = $signed({{(COEF_W-PARAM_W){1'b0}}, r_b});
        cq = $signed({{(COEF_W-PARAM_W){1'b0}}, r_c});
        // -32768 maps to 32768 in the unsigned magnitude
        n_side.t   = i_in.offset[OFFSET_W-1] ? t_mag'(-i_in.offset) : t_mag'(i_in.offset);
        near       = {16'd0, n_side.t} < ONE_Q;
        n_side.inr = {16'd0, n_side.t} < TWO_Q;
        if (near) begin
            n_c3      = 24'sd12 * Q14_ONE - 24'sd9 * bq - 24'sd6 * cq;
            n_c2      = -24'sd18 * Q14_ONE + 24'sd12 * bq + 24'sd6 * cq;
            n_side.c1 = '0;
            n_side.c0 = 24'sd6 * Q14_ONE - 24'sd2 * bq;
        end else begin
            n_c3      = -bq - 24'sd6 * cq;
            n_c2      = 24'sd6 * bq + 24'sd30 * cq;
            n_side.c1 = -24'sd12 * bq - 24'sd48 * cq;
            n_side.c0 = 24'sd8 * bq + 24'sd24 * cq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_side[0] <= n_side;
            r_c3      <= n_c3;
            r_c2      <= n_c2;
        end
        for (int k = 1; k < NS - 1; k++) begin
            if (en[k]) r_side[k] <= r_side[k-1];
        end
    end

    // ---------------- stages 1..6: Horner ----------------
    mcfw_horner #(.FRAC_BITS(FRAC_BITS)) u_h1 (
        .i_clk    (i_clk),
        .i_en     ('{en_a: en[1], en_b: en[2]}),
        .i_acc    (widen(r_c3)),
        .i_t      (r_side[0].t),
        .i_addend (widen(r_c2)),
        .o_acc    (h1_acc)
    );

    mcfw_horner #(.FRAC_BITS(FRAC_BITS)) u_h2 (
        .i_clk    (i_clk),
        .i_en     ('{en_a: en[3], en_b: en[4]}),
        .i_acc    (h1_acc),
        .i_t      (r_side[2].t),
        .i_addend (widen(r_side[2].c1)),
        .o_acc    (h2_acc)
    );

    mcfw_horner #(.FRAC_BITS(FRAC_BITS)) u_h3 (
        .i_clk    (i_clk),
        .i_en     ('{en_a: en[5], en_b: en[6]}),
        .i_acc    (h2_acc),
        .i_t      (r_side[4].t),
        .i_addend (widen(r_side[4].c0)),
        .o_acc    (h3_acc)
    );

    // ---------------- stages 7..9: /(6*2^14), mask, saturate ----------------
    // floor((acc + 3*2^14) / (6*2^14)) = floor(floor((acc + 3*2^14) / 2^15) / 3).
    // Bias by 3*2^26 so the /3 is unsigned and exact by reciprocal (u < 2^29).
    always_comb begin
        t_acc s;
        t_acc q;
        s   = h3_acc + DIV_BIAS;
        q   = s >>> (Q14_SHIFT + 1);
        n_u = {q[Q_W-1], q[Q_W-1:0]} + U_BIAS;
    end

    always_comb begin
        w_full = $signed({1'b0, r_prod[P_W-1:RCP_SHIFT]}) - Q_BIAS;
        if (!r_side[NS-2].inr) begin
            n_weight = '0;
        end else if (w_full > W_MAX) begin
            n_weight = W_MAX[WEIGHT_W-1:0];
        end else if (w_full < W_MIN) begin
            n_weight = W_MIN[WEIGHT_W-1:0];
        end else begin
            n_weight = w_full[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) r_u      <= n_u;
        if (en[8]) r_prod   <= r_u * RECIP3;
        if (en[9]) r_weight <= n_weight;
    end

    assign o_out.valid  = r_v[NS-1];
    assign o_out.weight = r_weight;

    // ---------------- assertions ----------------
    `MCFW_ASSERT(a_room_means_ready, i_clk, i_rst_n,
        (!(&r_v) |-> i_in.ready), "ready low with an empty stage")
    `MCFW_ASSERT(a_far_is_zero, i_clk, i_rst_n,
        ((r_v[8] && en[9] && !r_side[8].inr) |=> (o_out.weight == '0)),
        "nonzero weight beyond radius 2")
    `MCFW_ASSERT_RST(a_reset_state, i_clk,
        (!i_rst_n |=> (r_b == PARAM_RESET && r_c == PARAM_RESET && !o_out.valid)),
        "bad state after reset")

endmodule

// ----- rtl/mcfw_horner.sv -----
// One Horner step acc*t/2^FRAC_BITS + addend, split multiply over two stages.
module mcfw_horner #(
    parameter int FRAC_BITS = mcfw_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  mcfw_pkg::t_hstep_en   i_en,
    input  mcfw_pkg::t_acc        i_acc,
    input  mcfw_pkg::t_mag        i_t,
    input  mcfw_pkg::t_acc        i_addend,
    output mcfw_pkg::t_acc        o_acc
);
    import mcfw_pkg::*;

    localparam int HI_W   = ACC_W - ACC_LO_W;
    localparam int HI_P_W = HI_W + T_W + 1;
    localparam int LO_P_W = ACC_LO_W + T_W;
    localparam int PROD_W = HI_P_W + ACC_LO_W;
    localparam logic signed [PROD_W-1:0] HALF =
        {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic signed [HI_P_W-1:0] r_hi_p, n_hi_p;
    logic        [LO_P_W-1:0] r_lo_p, n_lo_p;
    t_acc                     r_addend;
    t_acc                     r_acc, n_acc;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;

    // stage a: partial products of the high (signed) and low (unsigned) halves
    always_comb begin
        n_hi_p = $signed(i_acc[ACC_W-1:ACC_LO_W]) * $signed({1'b0, i_t});
        n_lo_p = i_acc[ACC_LO_W-1:0] * i_t;
    end

    // stage b: recombine, round half up, rescale, add
    always_comb begin
        prod  = {r_hi_p, {ACC_LO_W{1'b0}}} + {{(PROD_W-LO_P_W){1'b0}}, r_lo_p};
        rnd   = (prod + HALF) >>> FRAC_BITS;
        n_acc = rnd[ACC_W-1:0] + r_addend;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_a) begin
            r_hi_p   <= n_hi_p;
            r_lo_p   <= n_lo_p;
            r_addend <= i_addend;
        end
        if (i_en.en_b) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- tb/mitchell_cubic_filter_weight_unit_test.sv -----
// Self-checking regression for the Mitchell-Netravali cubic filter weight unit.
module mitchell_cubic_filter_weight_unit_test;
    import mcfw_pkg::*;

    // Offset format and kernel constants (Q4.12 in, Q14 coefficients, Q28 sums).
    localparam int      FRAC         = FRAC_BITS_DEF;
    localparam longint  ONE_T        = longint'(1) << FRAC;
    localparam longint  Q14_ONE      = 16384;
    localparam longint  TO_Q28       = 16384;
    localparam longint  DIV_SIX_Q14  = longint'(6) << Q14_SHIFT;
    localparam int      NUM_PHASES   = 7;
    localparam int      RAND_WORDS   = 230;
    localparam int      DRAIN_CYCLES = 16;      // pipeline is ten stages deep
    localparam int      LIMIT_CYCLES = 200000;
    localparam t_cfg_idx FIRST_UNUSED_IDX = REG_C_PARAM + t_cfg_idx'(1);

    // Shape settings per phase; the last phase draws B and C at random.
    localparam t_param SHAPE_B [NUM_PHASES] =
        '{PARAM_RESET, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
    localparam t_param SHAPE_C [NUM_PHASES] =
        '{PARAM_RESET, 16'd8192, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0};

    // Expected weights in flight, plus a private copy of B and C.
    class weight_scoreboard;
        t_param      b_shape;
        t_param      c_shape;
        t_weight     weight_q[$];
        int unsigned mismatches;

        function new();
            b_shape    = PARAM_RESET;
            c_shape    = PARAM_RESET;
            mismatches = 0;
        endfunction

        // Writes to indexes past C are dropped by the block.
        function void set_param(t_cfg_idx idx, t_param val);
            case (idx)
                REG_B_PARAM: b_shape = val;
                REG_C_PARAM: c_shape = val;
                default: ;
            endcase
        endfunction

        // floor((v + d/2) / d), d > 0
        function longint round_half_up(longint v, longint d);
            longint num;
            longint quo;
            num = v + d / 2;
            quo = num / d;
            if ((num % d != 0) && (num < 0))
                quo = quo - 1;
            return quo;
        endfunction

        function t_weight mitchell_weight(t_offset x);
            longint t;
            longint bq;
            longint cq;
            longint k3;
            longint k2;
            longint k1;
            longint k0;
            longint acc;
            longint w;
            // |x| taken wide so the most negative offset stays 32768
            t  = (x < 0) ? -longint'(x) : longint'(x);
            bq = longint'(b_shape);
            cq = longint'(c_shape);
            if (t < ONE_T) begin
                k3 = (12 * Q14_ONE - 9 * bq - 6 * cq) * TO_Q28;
                k2 = (-18 * Q14_ONE + 12 * bq + 6 * cq) * TO_Q28;
                k1 = 0;
                k0 = (6 * Q14_ONE - 2 * bq) * TO_Q28;
            end else if (t < 2 * ONE_T) begin
                k3 = (-bq - 6 * cq) * TO_Q28;
                k2 = (6 * bq + 30 * cq) * TO_Q28;
                k1 = (-12 * bq - 48 * cq) * TO_Q28;
                k0 = (8 * bq + 24 * cq) * TO_Q28;
            end else begin
                return '0;      // outside radius 2
            end
            // Horner in Q28, rescaling each product by the offset's fraction bits
            acc = round_half_up(k3 * t, ONE_T) + k2;
            acc = round_half_up(acc * t, ONE_T) + k1;
            acc = round_half_up(acc * t, ONE_T) + k0;
            w   = round_half_up(acc, DIV_SIX_Q14);
            if (w > 32767)
                w = 32767;
            if (w < -32768)
                w = -32768;
            return t_weight'(w);
        endfunction

        function void note_offset(t_offset x);
            weight_q.push_back(mitchell_weight(x));
        endfunction

        function void check_weight(t_weight w);
            t_weight exp_w;
            if (weight_q.size() == 0) begin
                $error("weight: no word expected, got %0d", w);
                mismatches++;
            end else begin
                exp_w = weight_q.pop_front();
                if (w !== exp_w) begin
                    $error("weight: expected %0d, got %0d", exp_w, w);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return weight_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    bit          gaps_on = 1'b1;
    int unsigned cycle_count = 0;
    weight_scoreboard sb;

    mcfw_in_if  in_if ();
    mcfw_out_if out_if ();
    mcfw_cfg_if cfg_if ();

    mitchell_cubic_filter_weight_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Output back-pressure: ready drops at random with an 11 percent chance, never while gaps are off.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= !gaps_on || ($urandom_range(0, 99) >= 11);
    end

    // Monitor: all three channels are sampled at the edge, before any update lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.set_param(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready)
                sb.note_offset(in_if.offset);
            if (out_if.valid && out_if.ready)
                sb.check_weight(out_if.weight);
        end
    end

    // Mostly offsets inside the kernel support, some hugging the t = 1 and t = 2
    // boundaries, and the rest anywhere in the 16-bit range.
    function automatic t_offset rand_offset();
        int unsigned pick;
        int          mag;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return t_offset'($urandom);
        if (pick < 30)
            mag = int'($urandom_range(1, 2)) * int'(ONE_T) + int'($urandom_range(0, 8)) - 4;
        else
            mag = int'($urandom_range(0, 2 * int'(ONE_T) + 63));
        return ($urandom_range(0, 1) != 0) ? t_offset'(-mag) : t_offset'(mag);
    endfunction

    // One offset word; valid stays high across back-to-back words.
    task automatic send_offset(input t_offset x);
        while (gaps_on && ($urandom_range(0, 99) < 11)) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.offset <= x;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_reg(input t_cfg_idx idx, input t_param val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
    endtask

    // B and C, then a write to an unused index that must not disturb either.
    task automatic load_shape(input t_param b, input t_param c);
        write_reg(REG_B_PARAM, b);
        write_reg(REG_C_PARAM, c);
        write_reg(t_cfg_idx'($urandom_range(int'(FIRST_UNUSED_IDX), (1 << CFG_IDX_W) - 1)),
                  ($urandom_range(0, 1) != 0) ? 16'hFFFF : t_param'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Directed offsets: zero, tiny, the boundaries at t = 1 and t = 2 on both sides,
    // the far ends of the range and the most negative code.
    localparam t_offset EDGE_OFFSETS [20] = '{
        16'sd0, 16'sd1, -16'sd1, 16'sd2048, -16'sd2048, 16'sd4095, -16'sd4095,
        16'sd4096, -16'sd4096, 16'sd4097, 16'sd6144, 16'sd8191, -16'sd8191,
        16'sd8192, -16'sd8192, 16'sd8193, 16'sd16384, 16'sd32767, -16'sd32767,
        -16'sd32768
    };

    initial begin
        t_param b;
        t_param c;
        sb = new();
        in_if.valid  <= 1'b0;
        in_if.offset <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // phase 2 runs flat out on both sides
            gaps_on = (p != 2);
            if (p > 0) begin
                b = (p == NUM_PHASES - 1) ? t_param'($urandom) : SHAPE_B[p];
                c = (p == NUM_PHASES - 1) ? t_param'($urandom) : SHAPE_C[p];
                load_shape(b, c);
            end
            if (p == 0 || p == 3)
                foreach (EDGE_OFFSETS[i])
                    send_offset(EDGE_OFFSETS[i]);
            repeat (RAND_WORDS) send_offset(rand_offset());
            in_if.valid <= 1'b0;
            // shape registers only change with the pipeline empty
            wait_drained();
        end

        // let any stray output word show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("mitchell_cubic_filter_weight_unit regression: pass");
        else
            $display("mitchell_cubic_filter_weight_unit regression: fail");
        $finish;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge i_clk);
        $display("mitchell_cubic_filter_weight_unit regression: fail");
        $finish;
    end

endmodule
